// ===== rtl/core/egqt_pkg.sv =====
// Shared constants, quadrature lookup and controller/datapath interface types.
package egqt_pkg;

  localparam int ERROR_FRAC_BITS = 16;
  localparam int RAW_W           = 32;
  localparam int POS_W           = 48;
  localparam int DIV_W           = RAW_W + ERROR_FRAC_BITS;
  localparam int CNT_W           = $clog2(DIV_W);
  localparam int CFG_W           = 16;
  localparam int CFG_IDX_W       = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MASTER_LINES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLAVE_LINES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASTER_TEETH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLAVE_TEETH  = 2'd3;

  // Decoder code bits: low nibble is the next state
  localparam int EDGE_UP_BIT = 6;
  localparam int EDGE_DN_BIT = 7;

  localparam logic [63:0] SAT_NEG = 64'h0000_8000_0000_0000;
  localparam logic [63:0] SAT_POS = 64'h0000_7FFF_FFFF_FFFF;

  // Glitch-rejecting quadrature table, index = state | B<<1 | A
  function automatic logic [7:0] quad_lookup(input logic [3:0] idx);
    logic [7:0] code;
    case (idx)
      4'h0:    code = 8'h00;
      4'h1:    code = 8'h44;
      4'h2:    code = 8'h88;
      4'h3:    code = 8'h0C;
      4'h4:    code = 8'h80;
      4'h5:    code = 8'h04;
      4'h6:    code = 8'h08;
      4'h7:    code = 8'h4C;
      4'h8:    code = 8'h40;
      4'h9:    code = 8'h04;
      4'hA:    code = 8'h08;
      4'hB:    code = 8'h8C;
      4'hC:    code = 8'h00;
      4'hD:    code = 8'h84;
      4'hE:    code = 8'h48;
      default: code = 8'h0C;
    endcase
    return code;
  endfunction

  typedef struct packed {
    logic sample_ld;  // take a sample item and load the output register
    logic div_start;  // load dividend from the accumulator
    logic div_step;   // one restoring-division bit
    logic held_ld;    // store the finished quotient as the held error
    logic mul1;       // steps and lines product
    logic mul2;       // scale from lines product times slave teeth
    logic out_ld;     // load the output register for an update item
  } egqt_cmd_t;

  typedef struct packed {
    logic scale_zero;
    logic div_last;
  } egqt_sts_t;

endpackage

// ===== rtl/core/egqt_ctrl.sv =====
// Controller state machine: sequences sample items and the update item.
module egqt_ctrl import egqt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_command,
  input  logic      out_ready,
  input  egqt_sts_t sts,
  output logic      in_ready,
  output logic      out_valid,
  output egqt_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_FIN,
    S_MUL1,
    S_MUL2,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   accept;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && !in_command) begin
          cmd.sample_ld = 1'b1;
        end else if (accept) begin
          if (sts.scale_zero) begin
            state_nxt = S_MUL1;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.held_ld = 1'b1;
        state_nxt   = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.sample_ld || cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/egqt_dp.sv =====
// Datapath: decoders, error accumulator, ratio registers, divider, output register.
module egqt_dp import egqt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  egqt_cmd_t             cmd,
  output egqt_sts_t             sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  master_phase_a,
  input  logic                  master_phase_b,
  input  logic                  slave_phase_a,
  input  logic                  slave_phase_b,
  input  logic                  track_enable,
  output logic signed [RAW_W-1:0] raw_error_count,
  output logic signed [POS_W-1:0] position_error_revs
);

  logic [CFG_W-1:0] mlines_r, slines_r, mteeth_r, steeth_r;
  logic [3:0]       mst_r, sst_r;
  logic [RAW_W-1:0] acc_r, mstep_r, sstep_r, scale_r, prod_r;
  logic [POS_W-1:0] held_r;

  logic [DIV_W-1:0] quo_r;
  logic [RAW_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r;

  logic signed [RAW_W-1:0] out_raw_r;
  logic signed [POS_W-1:0] out_pos_r;

  logic [7:0]       m_code, s_code;
  logic [RAW_W-1:0] acc_m, acc_nxt;
  logic [RAW_W-1:0] mag;
  logic [RAW_W:0]   rem_sh, rem_diff;
  logic             rem_ge;
  logic [63:0]      q_ext, q_sat;
  logic [POS_W-1:0] held_nxt;

  // Decode and accumulate: master first, then slave
  always_comb begin
    m_code = quad_lookup(mst_r | {2'b00, master_phase_b, master_phase_a});
    s_code = quad_lookup(sst_r | {2'b00, slave_phase_b, slave_phase_a});
    acc_m  = acc_r;
    if (track_enable) begin
      if (m_code[EDGE_UP_BIT]) begin
        acc_m = acc_r - mstep_r;
      end else if (m_code[EDGE_DN_BIT]) begin
        acc_m = acc_r + mstep_r;
      end
    end
    acc_nxt = acc_m;
    if (s_code[EDGE_UP_BIT]) begin
      acc_nxt = acc_m + sstep_r;
    end else if (s_code[EDGE_DN_BIT]) begin
      acc_nxt = acc_m - sstep_r;
    end
  end

  // Restoring division, one quotient bit a cycle
  assign mag      = acc_r[RAW_W-1] ? (~acc_r + 1'b1) : acc_r;
  assign rem_sh   = {rem_r, quo_r[DIV_W-1]};
  assign rem_diff = rem_sh - {1'b0, scale_r};
  assign rem_ge   = (rem_sh >= {1'b0, scale_r});

  always_comb begin
    q_ext = 64'(quo_r);
    q_sat = q_ext;
    if (neg_r && (q_ext > SAT_NEG)) begin
      q_sat = SAT_NEG;
    end else if (!neg_r && (q_ext > SAT_POS)) begin
      q_sat = SAT_POS;
    end
    held_nxt = neg_r ? POS_W'(64'd0 - q_sat) : POS_W'(q_sat);
  end

  assign sts.scale_zero = (scale_r == '0);
  assign sts.div_last   = (cnt_r == '0);

  // Architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mlines_r <= '0;
      slines_r <= '0;
      mteeth_r <= '0;
      steeth_r <= '0;
      mst_r    <= '0;
      sst_r    <= '0;
      acc_r    <= '0;
      mstep_r  <= '0;
      sstep_r  <= '0;
      scale_r  <= RAW_W'(1);
      held_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MASTER_LINES: mlines_r <= cfg_data;
          REG_SLAVE_LINES:  slines_r <= cfg_data;
          REG_MASTER_TEETH: mteeth_r <= cfg_data;
          REG_SLAVE_TEETH:  steeth_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.sample_ld) begin
        mst_r <= m_code[3:0];
        sst_r <= s_code[3:0];
        acc_r <= acc_nxt;
      end
      if (cmd.held_ld) begin
        held_r <= held_nxt;
      end
      if (cmd.mul1) begin
        mstep_r <= RAW_W'(mteeth_r) * RAW_W'(slines_r);
        sstep_r <= RAW_W'(steeth_r) * RAW_W'(mlines_r);
      end
      if (cmd.mul2) begin
        scale_r <= prod_r * RAW_W'(steeth_r);
      end
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo_r <= {mag, {ERROR_FRAC_BITS{1'b0}}};
      rem_r <= '0;
      cnt_r <= CNT_W'(DIV_W - 1);
      neg_r <= acc_r[RAW_W-1];
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[DIV_W-2:0], rem_ge};
      rem_r <= rem_ge ? rem_diff[RAW_W-1:0] : rem_sh[RAW_W-1:0];
      cnt_r <= cnt_r - 1'b1;
    end
    if (cmd.mul1) begin
      prod_r <= RAW_W'(mlines_r) * RAW_W'(slines_r);
    end
    if (cmd.sample_ld) begin
      out_raw_r <= acc_nxt;
      out_pos_r <= held_r;
    end else if (cmd.out_ld) begin
      out_raw_r <= acc_r;
      out_pos_r <= held_r;
    end
  end

  assign raw_error_count     = out_raw_r;
  assign position_error_revs = out_pos_r;

endmodule

// ===== rtl/core/electronic_gear_quadrature_tracker.sv =====
// Top level of the electronic gear quadrature tracker.
//
//  channel | direction | ports                                      | handshake
//  --------+-----------+--------------------------------------------+----------------
//  in      | input     | in_command, in_*_phase_a/b, in_track_enable| in_valid/in_ready
//  out     | output    | out_raw_error_count, out_position_error_revs| out_valid/out_ready
//  cfg     | input     | cfg_index, cfg_data                        | cfg_valid/cfg_ready
//
// Sample items may follow back to back while the output register drains; the result
//   sits in the output register the cycle after acceptance.
// Update items run the restoring divider (one quotient bit a cycle, Q32.16 result),
//   then S_FIN, S_MUL1, S_MUL2 and S_OUT; a zero scale skips S_DIV and S_FIN.
// A result that is not taken holds in_ready low; with out_ready high a new
//   item and the drain of the output register share a cycle.
// Synchronous active-low reset; no clearing pass. cfg writes are always taken.
module electronic_gear_quadrature_tracker import egqt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  // item input
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_command,
  input  logic                    in_master_phase_a,
  input  logic                    in_master_phase_b,
  input  logic                    in_slave_phase_a,
  input  logic                    in_slave_phase_b,
  input  logic                    in_track_enable,
  // result output
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [RAW_W-1:0] out_raw_error_count,
  output logic signed [POS_W-1:0] out_position_error_revs,
  // register writes
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  egqt_cmd_t cmd;
  egqt_sts_t sts;

  // Registers are plain flops, so a write never has to wait
  assign cfg_ready = 1'b1;

  egqt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .out_ready  (out_ready),
    .sts        (sts),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .cmd        (cmd)
  );

  egqt_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .master_phase_a      (in_master_phase_a),
    .master_phase_b      (in_master_phase_b),
    .slave_phase_a       (in_slave_phase_a),
    .slave_phase_b       (in_slave_phase_b),
    .track_enable        (in_track_enable),
    .raw_error_count     (out_raw_error_count),
    .position_error_revs (out_position_error_revs)
  );

  // A sample item always has its result ready the next cycle
  a_sample_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_command) |=> out_valid)
    else $error("sample item did not produce a result");

  // An update item keeps the input closed after its acceptance
  a_update_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_command) |=> !in_ready ##1 !in_ready)
    else $error("input reopened during update");

  // Only one command is issued at a time
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("conflicting datapath commands");

  // Sample and division never start while the divider is running
  a_div_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |=> !(cmd.sample_ld || cmd.div_start))
    else $error("datapath reused during division");

endmodule

// ===== tb/egqt_gear_checker.sv =====
// Command codes and the result checker (predictor plus scoreboard) for the gear tracker.
package egqt_tb_pkg;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_UPDATE = 1'b1
  } gear_cmd_e;

endpackage

module egqt_gear_checker import egqt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    in_command,
  input  logic                    in_master_phase_a,
  input  logic                    in_master_phase_b,
  input  logic                    in_slave_phase_a,
  input  logic                    in_slave_phase_b,
  input  logic                    in_track_enable,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [RAW_W-1:0] out_raw_error_count,
  input  logic signed [POS_W-1:0] out_position_error_revs,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  output int                      gear_errors,
  output int                      results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  import egqt_tb_pkg::*;

  localparam int MAX_REPORTS = 10;

  // quadrature codes, entry 15 first
  localparam logic [16*8-1:0] QUAD_CODES = {
    8'h0C, 8'h48, 8'h84, 8'h00, 8'h8C, 8'h08, 8'h04, 8'h40,
    8'h4C, 8'h08, 8'h04, 8'h80, 8'h0C, 8'h88, 8'h44, 8'h00
  };

  localparam logic [63:0] NEG_LIMIT = 64'd1 << (POS_W - 1);
  localparam logic [63:0] POS_LIMIT = NEG_LIMIT - 64'd1;

  typedef struct packed {
    logic [RAW_W-1:0] raw;
    logic [POS_W-1:0] revs;
  } gear_result_t;

  gear_result_t due_results[$];

  // register copies
  logic [CFG_W-1:0] master_lines, slave_lines, master_tooth_cnt, slave_tooth_cnt;

  // tracker state
  logic [3:0]       master_quad, slave_quad;
  logic [RAW_W-1:0] error_acc, master_step, slave_step, error_scale;
  logic [POS_W-1:0] held_revs;

  initial begin
    gear_errors = 0;
    results_due = 0;
  end

  function automatic logic [7:0] quad_code(input logic [3:0] st, input logic a, input logic b);
    int idx;
    idx = int'(st | {2'b00, b, a});
    return QUAD_CODES[idx*8 +: 8];
  endfunction

  // signed Q format revolutions, quotient truncated toward zero
  function automatic logic [POS_W-1:0] gear_error_revs(input logic [RAW_W-1:0] raw,
                                                       input logic [RAW_W-1:0] scale);
    logic [RAW_W-1:0] neg_raw;
    logic [63:0]      mag, quo;
    neg_raw = ~raw + 1'b1;
    mag = raw[RAW_W-1] ? 64'(neg_raw) : 64'(raw);
    quo = (mag << ERROR_FRAC_BITS) / 64'(scale);
    if (raw[RAW_W-1]) begin
      if (quo > NEG_LIMIT) quo = NEG_LIMIT;
      quo = 64'd0 - quo;
    end else if (quo > POS_LIMIT) begin
      quo = POS_LIMIT;
    end
    return quo[POS_W-1:0];
  endfunction

  task automatic track_sample();
    logic [7:0] m_code, s_code;
    m_code = quad_code(master_quad, in_master_phase_a, in_master_phase_b);
    master_quad = m_code[3:0];
    if (in_track_enable) begin
      if (m_code[EDGE_UP_BIT]) error_acc = error_acc - master_step;
      else if (m_code[EDGE_DN_BIT]) error_acc = error_acc + master_step;
    end
    s_code = quad_code(slave_quad, in_slave_phase_a, in_slave_phase_b);
    slave_quad = s_code[3:0];
    if (s_code[EDGE_UP_BIT]) error_acc = error_acc + slave_step;
    else if (s_code[EDGE_DN_BIT]) error_acc = error_acc - slave_step;
  endtask

  task automatic latch_gear();
    logic [RAW_W-1:0] lines_prod;
    if (error_scale != '0) held_revs = gear_error_revs(error_acc, error_scale);
    master_step = {16'd0, master_tooth_cnt} * {16'd0, slave_lines};
    slave_step  = {16'd0, slave_tooth_cnt} * {16'd0, master_lines};
    lines_prod  = {16'd0, master_lines} * {16'd0, slave_lines};
    error_scale = lines_prod * {16'd0, slave_tooth_cnt};
  endtask

  task automatic report_bad(input string what, input gear_result_t want);
    gear_errors++;
    if (gear_errors <= MAX_REPORTS)
      $display("%t gear %s: want raw %h revs %h, got raw %h revs %h", $realtime, what,
               want.raw, want.revs, out_raw_error_count, out_position_error_revs);
  endtask

  always @(posedge clk) begin
    gear_result_t want;
    if (!rst_n) begin
      master_lines     = '0;
      slave_lines      = '0;
      master_tooth_cnt = '0;
      slave_tooth_cnt  = '0;
      master_quad      = '0;
      slave_quad       = '0;
      error_acc        = '0;
      master_step      = '0;
      slave_step       = '0;
      error_scale      = 32'd1;
      held_revs        = '0;
      due_results.delete();
      results_due <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MASTER_LINES: master_lines     = cfg_data;
          REG_SLAVE_LINES:  slave_lines      = cfg_data;
          REG_MASTER_TEETH: master_tooth_cnt = cfg_data;
          REG_SLAVE_TEETH:  slave_tooth_cnt  = cfg_data;
          default: ;
        endcase
      end
      // results first, so an item taken on this edge cannot cover a stray result
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          report_bad("result with nothing due", '0);
        end else begin
          want = due_results.pop_front();
          if (out_raw_error_count !== want.raw || out_position_error_revs !== want.revs)
            report_bad("mismatch", want);
        end
      end
      if (in_valid && in_ready) begin
        if (in_command == CMD_UPDATE) latch_gear();
        else track_sample();
        due_results.push_back('{raw: error_acc, revs: held_revs});
      end
      results_due <= due_results.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// Top of the gear tracker testbench: clock, reset, stimulus, flow control and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import egqt_pkg::*;
  import egqt_tb_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 4;
  localparam int MAX_IDLE      = 11;
  localparam int GEAR_SETS     = 7;
  localparam int ITEMS_PER_SET = 146;
  localparam int LONG_HOLD     = 400;     // receiver hold-off, cycles
  localparam int TAIL_CYCLES   = 64;      // longer than one full update
  localparam int CYCLE_LIMIT   = 500000;  // watchdog bound on the whole run

  // quadrature levels {B,A} per position, position 3 first
  localparam logic [7:0] GRAY_LV = {2'b10, 2'b11, 2'b01, 2'b00};

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_valid          = 1'b0;
  logic                    in_ready;
  logic                    in_command        = 1'b0;
  logic                    in_master_phase_a = 1'b0;
  logic                    in_master_phase_b = 1'b0;
  logic                    in_slave_phase_a  = 1'b0;
  logic                    in_slave_phase_b  = 1'b0;
  logic                    in_track_enable   = 1'b0;
  logic                    out_valid;
  logic                    out_ready         = 1'b0;
  logic signed [RAW_W-1:0] out_raw_error_count;
  logic signed [POS_W-1:0] out_position_error_revs;
  logic                    cfg_valid         = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index         = '0;
  logic [CFG_W-1:0]        cfg_data          = '0;

  int gear_errors;
  int results_due;

  // encoder model used to build well-formed phase sequences
  int   m_pos = 0, s_pos = 0;
  int   m_dir = 1, s_dir = -1;
  logic track_en = 1'b1;

  // sender idling: stretches with no gaps alternate with random gaps
  bit tx_calm      = 1'b0;
  int tx_calm_left = 0;

  // set by the stimulus, consumed by the receiver
  bit hold_req    = 1'b0;
  int cycle_count = 0;

  electronic_gear_quadrature_tracker u_dut (.*);

  egqt_gear_checker u_checker (.*);

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Watchdog: anything that hangs (lost result, stuck ready) ends here.
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stall before each result, calm stretches in between,
  // and one long hold-off on request so the block backs up into in_ready.
  initial begin
    int stall, calm_left;
    bit calm;
    calm_left = 0;
    calm = 1'b0;
    forever begin
      if (calm_left == 0) begin
        calm = ($urandom_range(0, 2) == 0);
        calm_left = $urandom_range(8, 40);
      end
      calm_left--;
      stall = calm ? 0 : $urandom_range(0, MAX_IDLE);
      if (hold_req) begin
        hold_req = 1'b0;
        stall += LONG_HOLD;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  function automatic logic [1:0] lv_of(input int pos);
    return GRAY_LV[pos*2 +: 2];
  endfunction

  function automatic int level_pos(input logic [1:0] lv);
    case (lv)
      2'b00:   return 0;
      2'b01:   return 1;
      2'b11:   return 2;
      default: return 3;
    endcase
  endfunction

  // Offer one item; returns on the edge it is taken.
  task automatic offer(input gear_cmd_e cmd, input logic [1:0] m_lv, input logic [1:0] s_lv,
                       input logic en);
    int gap;
    if (tx_calm_left == 0) begin
      tx_calm = ($urandom_range(0, 2) == 0);
      tx_calm_left = $urandom_range(8, 40);
    end
    tx_calm_left--;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_command        <= cmd;
    in_master_phase_a <= m_lv[0];
    in_master_phase_b <= m_lv[1];
    in_slave_phase_a  <= s_lv[0];
    in_slave_phase_b  <= s_lv[1];
    in_track_enable   <= en;
    in_valid          <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Update item; phase bits are don't-care here, so they get noise.
  task automatic offer_update();
    offer(CMD_UPDATE, 2'($urandom), 2'($urandom), 1'($urandom));
  endtask

  // Sample item with both encoders moved by the given steps.
  task automatic move(input int m_delta, input int s_delta, input logic en);
    m_pos = (m_pos + m_delta + 4) % 4;
    s_pos = (s_pos + s_delta + 4) % 4;
    offer(CMD_SAMPLE, lv_of(m_pos), lv_of(s_pos), en);
  endtask

  // Drop valid and wait until every result has come back.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
  endtask

  task automatic apply_gear(input logic [CFG_W-1:0] ml, input logic [CFG_W-1:0] sl,
                            input logic [CFG_W-1:0] mt, input logic [CFG_W-1:0] st);
    write_reg(REG_MASTER_LINES, ml);
    write_reg(REG_SLAVE_LINES, sl);
    write_reg(REG_MASTER_TEETH, mt);
    write_reg(REG_SLAVE_TEETH, st);
    cfg_valid <= 1'b0;
  endtask

  // Encoder keeps its direction most of the time, sometimes dwells or reverses.
  task automatic step_encoder(inout int pos, inout int dir);
    if ($urandom_range(0, 19) == 0) dir = -dir;
    if ($urandom_range(0, 9) < 7) pos = (pos + dir + 4) % 4;
  endtask

  // Mostly clean quadrature motion; some glitches, some updates.
  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      offer_update();
    end else begin
      step_encoder(m_pos, m_dir);
      step_encoder(s_pos, s_dir);
      if (r >= 90) begin
        case ($urandom_range(0, 2))
          0: m_pos = level_pos(2'($urandom));
          1: s_pos = level_pos(2'($urandom));
          default: begin
            // both phases flip at once: illegal jump
            m_pos = (m_pos + 2) % 4;
            s_pos = (s_pos + 2) % 4;
          end
        endcase
      end
      if ($urandom_range(0, 19) == 0) track_en = ~track_en;
      offer(CMD_SAMPLE, lv_of(m_pos), lv_of(s_pos), track_en);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] ml, sl, mt, st;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed ---
    // update straight out of reset: scale 1, zero error
    offer_update();
    wait_results_done();
    // master step 3, slave step 1, scale 3: exercises truncation toward zero
    apply_gear(16'd1, 16'd3, 16'd1, 16'd1);
    offer_update();
    repeat (4) move(1, 0, 1'b1);
    repeat (2) move(-1, 0, 1'b1);
    repeat (2) move(1, 0, 1'b0);      // tracking off: master ignored
    offer_update();
    repeat (3) move(0, 1, 1'b1);
    move(0, -1, 1'b1);
    move(2, 0, 1'b1);                 // master glitch
    move(0, 2, 1'b1);                 // slave glitch
    move(1, -1, 1'b1);
    offer_update();
    offer(CMD_SAMPLE, 2'b11, 2'b11, 1'b1);
    m_pos = level_pos(2'b11);
    s_pos = level_pos(2'b11);
    offer(CMD_UPDATE, 2'b11, 2'b11, 1'b1);

    // --- random, one gear setting per set ---
    for (int set = 0; set < GEAR_SETS; set++) begin
      wait_results_done();
      case (set)
        0: begin
          ml = '1; sl = '1; mt = '1; st = '1;
        end
        1: begin
          // zero scale: updates keep the held value
          ml = '0; sl = '0; mt = '0; st = '0;
        end
        2: begin
          ml = 16'd4; sl = 16'd4; mt = 16'd1; st = 16'd1;
        end
        3: begin
          // huge master step with unit scale
          ml = 16'd1; sl = 16'd1; mt = '1; st = 16'd1;
        end
        4: begin
          ml = 16'($urandom); sl = 16'($urandom); mt = 16'($urandom); st = 16'($urandom);
        end
        5: begin
          ml = 16'($urandom_range(1, 64)); sl = 16'($urandom_range(1, 64));
          mt = 16'($urandom_range(1, 64)); st = 16'($urandom_range(1, 64));
        end
        default: begin
          // no master lines: zero scale and zero slave step, master step live
          ml = '0; sl = 16'($urandom); mt = 16'($urandom); st = 16'($urandom);
        end
      endcase
      apply_gear(ml, sl, mt, st);
      offer_update();                 // converts with the old scale, latches the new one
      for (int i = 0; i < ITEMS_PER_SET; i++) begin
        if (set == 2 && i == 40) hold_req = 1'b1;
        if (set == 4 && i == 70) wait_results_done();
        random_item();
      end
    end

    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (gear_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/egqt_pkg.sv
rtl/core/egqt_ctrl.sv
rtl/core/egqt_dp.sv
rtl/core/electronic_gear_quadrature_tracker.sv
tb/egqt_gear_checker.sv
tb/tb.sv
